/* hw/rtl/base64_stream_decoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit_macros : assertion helpers
// Concurrent assertion wrappers clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication
`define BSD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Types, codes and the character lookup shared by the Base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  // Sextet lookup codes beyond the 64 alphabet values
  localparam logic [6:0] SX_PAD = 7'd64;
  localparam logic [6:0] SX_BAD = 7'd65;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Stream status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_LENGTH      = 3'd1;
  localparam logic [2:0] ST_BAD_LEADING = 3'd2;
  localparam logic [2:0] ST_BAD_PADDING = 3'd3;
  localparam logic [2:0] ST_BAD_THIRD   = 3'd4;
  localparam logic [2:0] ST_BAD_FOURTH  = 3'd5;

  // Results raised by one input beat: data bytes first, then the status
  typedef struct packed {
    logic [1:0]  n_data;
    logic        has_status;
    logic [2:0]  status;
    logic [23:0] tri_bytes;
  } bundle_t;

  // Map a character to its sextet, SX_PAD for '=' or SX_BAD otherwise
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] v;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = 7'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = 7'(ch - 8'h47);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 7'(ch + 8'h04);
    end else if (ch == 8'h2B) begin
      v = 7'd62;
    end else if (ch == 8'h2F) begin
      v = 7'd63;
    end else if (ch == 8'h3D) begin
      v = SX_PAD;
    end else begin
      v = SX_BAD;
    end
    return v;
  endfunction

  // Tab, line feed, vertical tab, form feed, carriage return and space
  function automatic logic is_blank(input logic [7:0] ch);
    return (ch >= 8'h09 && ch <= 8'h0D) || ch == 8'h20;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bsd_core.sv */
// ----------------------------------------------------------------------------
// bsd_core
// Group state of the decoder and the per-character decode into a bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      char_byte,
  input  wire logic            end_of_input,
  output bsd_pkg::bundle_t     bundle,
  output logic                 produce
);
  import bsd_pkg::*;

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        twp_r, twp_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [6:0]  v;
  logic [5:0]  v6;
  logic        pad4;

  // Decode one character against the current group state
  always_comb begin
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    twp_nxt = twp_r;
    err_nxt = err_r;
    bundle  = '0;
    v       = sextet_of(char_byte);
    v6      = (v >= SX_PAD) ? 6'd0 : v[5:0];
    pad4    = (v == SX_PAD);

    if (!is_blank(char_byte)) begin
      case (pos_r)
        2'd0, 2'd1: begin
          if (v >= SX_PAD && err_nxt == ST_OK) err_nxt = ST_BAD_LEADING;
          acc_nxt = {acc_r[11:0], v6};
        end
        2'd2: begin
          twp_nxt = pad4;
          if (v == SX_BAD && err_nxt == ST_OK) err_nxt = ST_BAD_THIRD;
          acc_nxt = {acc_r[11:0], v6};
        end
        default: begin
          if (twp_r && !pad4 && err_nxt == ST_OK) err_nxt = ST_BAD_PADDING;
          if (v == SX_BAD && err_nxt == ST_OK) err_nxt = ST_BAD_FOURTH;
          if (err_nxt == ST_OK) begin
            bundle.tri_bytes = {acc_r, v6};
            bundle.n_data    = 2'd1 + {1'b0, !twp_r} + {1'b0, !pad4};
          end
          acc_nxt = '0;
          twp_nxt = 1'b0;
        end
      endcase
      pos_nxt = pos_r + 2'd1;
    end

    // Close the stream: length check overrides any kept error
    if (end_of_input) begin
      bundle.has_status = 1'b1;
      bundle.status     = (pos_nxt != 2'd0) ? ST_LENGTH : err_nxt;
      pos_nxt = '0;
      acc_nxt = '0;
      twp_nxt = 1'b0;
      err_nxt = ST_OK;
    end

    produce = bundle.has_status || (bundle.n_data != 2'd0);
  end

  // Advance group state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
      twp_r <= 1'b0;
      err_r <= ST_OK;
    end else if (accept) begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      twp_r <= twp_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming Base64 decoder, one character per input beat.
// ----------------------------------------------------------------------------
// Takes one character per cycle while in_stall is low. Whitespace is skipped;
// every fourth significant character releases one to three decoded bytes,
// and the end-of-input beat adds a final status result. Results leave one per
// cycle from a result register with out_stall low; a beat raising several (at
// most four) holds the input until its last is taken, so beats with zero or
// one result stream at one per cycle. The first error is kept and suppresses
// later bytes; bytes already delivered before an error are to be discarded.
`default_nettype none

module base64_stream_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_end_of_input,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_result_kind,
  output logic [7:0]      out_data_byte,
  output logic [2:0]      out_status_code,
  output logic            out_run_last
);
  import bsd_pkg::*;
  `include "base64_stream_decoder_unit_macros.svh"

  bundle_t    new_bundle;
  logic       produce;
  logic       accept;

  logic       bv_r;
  bundle_t    bundle_r;
  logic [1:0] idx_r;

  logic [2:0] n_tot;
  logic       last_sel;
  logic       take;
  logic       done;

  // Decode core
  bsd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .char_byte    (in_char_byte),
    .end_of_input (in_end_of_input),
    .bundle       (new_bundle),
    .produce      (produce)
  );

  // Track the result being presented
  assign n_tot    = {1'b0, bundle_r.n_data} + {2'b0, bundle_r.has_status};
  assign last_sel = ({1'b0, idx_r} == (n_tot - 3'd1));
  assign take     = bv_r && !out_stall;
  assign done     = take && last_sel;

  // Hold input until the last result in the register is taken
  assign in_stall = bv_r && !done;
  assign accept   = in_valid && !in_stall;

  // Load a new bundle or step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      idx_r <= '0;
    end else if (accept && produce) begin
      bv_r  <= 1'b1;
      idx_r <= '0;
    end else if (done) begin
      bv_r  <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept && produce) begin
      bundle_r <= new_bundle;
    end
  end

  // Drive the result fields
  always_comb begin
    out_valid       = bv_r;
    out_result_kind = (idx_r == bundle_r.n_data) ? KIND_STATUS : KIND_DATA;
    out_run_last    = last_sel;
    out_status_code = (out_result_kind == KIND_STATUS) ? bundle_r.status : ST_OK;
    case (idx_r)
      2'd0:    out_data_byte = bundle_r.tri_bytes[23:16];
      2'd1:    out_data_byte = bundle_r.tri_bytes[15:8];
      2'd2:    out_data_byte = bundle_r.tri_bytes[7:0];
      default: out_data_byte = 8'h00;
    endcase
    if (out_result_kind == KIND_STATUS) out_data_byte = 8'h00;
  end

  // Checks
  `BSD_ASSERT_IMPL(a_idx_in_range, bv_r, ({1'b0, idx_r} < n_tot), "result index past bundle")
  `BSD_ASSERT_IMPL(a_status_last, bv_r && out_result_kind == KIND_STATUS, out_run_last,
    "status result not last")
  `BSD_ASSERT_NEXT(a_load_starts, accept && produce, bv_r && idx_r == 2'd0,
    "new bundle not loaded")
  `BSD_ASSERT_NEXT(a_partial_holds, take && !last_sel, bv_r && idx_r == $past(idx_r) + 2'd1,
    "bundle dropped before its last result")

endmodule

`default_nettype wire
